// ----- hw/rtl/matrix3x3_inverse_unit_assert.svh -----
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef MATRIX3X3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3X3_INVERSE_UNIT_ASSERT_SVH

// Property holds at every edge.
`define M3I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define M3I_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/m3i_pkg.sv -----
package m3i_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NUM_ELEM  = 9;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned ADJ_W     = 2 * ELEM_W;
  localparam int unsigned HALF_W    = ADJ_W / 2;
  localparam int unsigned LO_W      = ELEM_W + HALF_W + 1;
  localparam int unsigned DET_W     = ELEM_W + ADJ_W + 2;
  localparam int unsigned THR_W     = 31;
  localparam int unsigned LIM_W     = THR_W + 2 * FRAC_BITS;
  localparam int unsigned NUM_W     = ADJ_W + 2 * FRAC_BITS;
  localparam int unsigned QB        = ELEM_W + 1;
  localparam int unsigned DIV_W     = DET_W + QB;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_THR_ADDR = 3'd0;
  localparam logic [THR_W-1:0]  THR_RESET    = 31'd7;

  // Cofactor terms per adjugate entry: e[a]*e[b] - e[c]*e[d], flat index r*3+c.
  localparam int unsigned ADJ_TERM [NUM_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;

  typedef struct packed {
    adj_t [NUM_ELEM-1:0] adj;
    logic [DET_W-1:0]    dmag;
    logic                dneg;
    logic                singular;
  } m3i_job_t;

endpackage

// ----- hw/rtl/m3i_front.sv -----
module m3i_front import m3i_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  elem_t [NUM_ELEM-1:0]       in_elem_i,
  input  logic [THR_W-1:0]           thr_i,
  input  logic                       job_full_i,
  output logic                       job_push_o,
  output m3i_job_t                   job_o
);

  logic [4:0] v_q, v_d;
  logic       adv;

  adj_t [NUM_ELEM-1:0] pa_q, pa_d, pb_q, pb_d;
  adj_t [NUM_ELEM-1:0] adj2_q, adj2_d, adj3_q, adj4_q;
  elem_t [2:0]         e1_q, e2_q;
  logic signed [LO_W-1:0]   lo_q [3];
  logic signed [LO_W-1:0]   lo_d [3];
  logic signed [ADJ_W-1:0]  hi_q [3];
  logic signed [ADJ_W-1:0]  hi_d [3];
  logic signed [DET_W-1:0]  det_q, det_d;
  m3i_job_t                 job_q, job_d;

  assign adv        = !(v_q[4] && job_full_i);
  assign in_ready_o = adv;
  assign job_push_o = v_q[4] && !job_full_i;
  assign job_o      = job_q;
  assign v_d        = {v_q[3:0], in_valid_i};

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      pa_d[k] = $signed(in_elem_i[ADJ_TERM[k][0]]) * $signed(in_elem_i[ADJ_TERM[k][1]]);
      pb_d[k] = $signed(in_elem_i[ADJ_TERM[k][2]]) * $signed(in_elem_i[ADJ_TERM[k][3]]);
      adj2_d[k] = $signed(pa_q[k]) - $signed(pb_q[k]);
    end
  end

  // det = sum over row 0 of e0j * adj[j][0], 32x64 split into two 32-bit halves
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lo_d[j] = $signed(e2_q[j]) * $signed({1'b0, adj2_q[j*3][HALF_W-1:0]});
      hi_d[j] = $signed(e2_q[j]) * $signed(adj2_q[j*3][ADJ_W-1:HALF_W]);
    end
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d
            + $signed({{(DET_W-ADJ_W-HALF_W){hi_q[j][ADJ_W-1]}}, hi_q[j], {HALF_W{1'b0}}})
            + $signed({{(DET_W-LO_W){lo_q[j][LO_W-1]}}, lo_q[j]});
    end
  end

  always_comb begin
    logic [DET_W-1:0] lim;
    lim          = DET_W'({thr_i, {(2*FRAC_BITS){1'b0}}});
    job_d.adj    = adj4_q;
    job_d.dneg   = det_q[DET_W-1];
    job_d.dmag   = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
    job_d.singular = (job_d.dmag < lim) || (job_d.dmag == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      e1_q   <= in_elem_i[2:0];
      adj2_q <= adj2_d;
      e2_q   <= e1_q;
      adj3_q <= adj2_q;
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= lo_d[j];
        hi_q[j] <= hi_d[j];
      end
      adj4_q <= adj3_q;
      det_q  <= det_d;
      job_q  <= job_d;
    end
  end

endmodule

// ----- hw/rtl/m3i_fifo.sv -----
module m3i_fifo import m3i_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  m3i_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output m3i_job_t data_o
);

  m3i_job_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_CW-1:0]   count_q;

  assign full_o  = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      count_q <= count_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  `include "matrix3x3_inverse_unit_assert.svh"

  `M3I_ASSERT(a_push_room, push_i |-> !full_o, "push into full queue")
  `M3I_ASSERT(a_pop_data, pop_i |-> !empty_o, "pop from empty queue")
  `M3I_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count slip")

endmodule

// ----- hw/rtl/m3i_back.sv -----
module m3i_back import m3i_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  m3i_job_t              job_i,
  output logic                  job_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output elem_t [NUM_ELEM-1:0]  out_res_o,
  output logic                  out_status_o
);

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [QB-1:0]     quo;
    logic              neg;
    logic              ovf;
    logic [ELEM_W-1:0] rsing;
  } m3i_lane_t;

  typedef struct packed {
    m3i_lane_t [NUM_ELEM-1:0] lane;
    logic [DET_W-1:0]         dmag;
    logic                     singular;
  } m3i_div_t;

  function automatic logic [ELEM_W-1:0] sat32(input logic neg, input logic [ADJ_W-1:0] mag);
    logic [ADJ_W-1:0] pmax, nmax;
    logic [ELEM_W-1:0] r;
    pmax = {{(ADJ_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
    nmax = ADJ_W'(1) << (ELEM_W - 1);
    if (!neg) begin
      r = (mag > pmax) ? pmax[ELEM_W-1:0] : mag[ELEM_W-1:0];
    end else begin
      r = (mag > nmax) ? nmax[ELEM_W-1:0] : ELEM_W'(0) - mag[ELEM_W-1:0];
    end
    return r;
  endfunction

  logic                 adv;
  logic [QB:0]          dvv_q;
  m3i_div_t             dv_q  [QB+1];
  m3i_div_t             dv_nx [QB];
  m3i_div_t             prep_d;
  logic                 out_valid_q;
  elem_t [NUM_ELEM-1:0] res_q, res_d;
  logic                 status_q;

  assign adv          = !out_valid_q || out_ready_i;
  assign job_pop_o    = adv && job_valid_i;
  assign out_valid_o  = out_valid_q;
  assign out_res_o    = res_q;
  assign out_status_o = status_q;

  always_comb begin
    logic [ADJ_W-1:0] amag;
    logic             aneg;
    prep_d.dmag     = job_i.dmag;
    prep_d.singular = job_i.singular;
    for (int k = 0; k < NUM_ELEM; k++) begin
      aneg = job_i.adj[k][ADJ_W-1];
      amag = aneg ? ADJ_W'(0) - job_i.adj[k] : job_i.adj[k];
      prep_d.lane[k].rem   = {amag, {(2*FRAC_BITS){1'b0}}};
      // quotient would not fit in QB bits
      prep_d.lane[k].ovf   = DIV_W'(prep_d.lane[k].rem) >= (DIV_W'(job_i.dmag) << QB);
      prep_d.lane[k].quo   = '0;
      prep_d.lane[k].neg   = aneg ^ job_i.dneg;
      prep_d.lane[k].rsing = sat32(aneg, amag >> FRAC_BITS);
    end
  end

  // one restoring quotient bit per stage, MSB first
  always_comb begin
    logic [DIV_W-1:0] dsh;
    logic [DIV_W-1:0] rw;
    for (int s = 0; s < QB; s++) begin
      dv_nx[s] = dv_q[s];
      dsh = DIV_W'(dv_q[s].dmag) << (QB - 1 - s);
      for (int k = 0; k < NUM_ELEM; k++) begin
        rw = DIV_W'(dv_q[s].lane[k].rem);
        if (rw >= dsh) begin
          dv_nx[s].lane[k].rem = NUM_W'(rw - dsh);
          dv_nx[s].lane[k].quo[QB-1-s] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_ELEM; k++) begin
      res_d[k] = dv_q[QB].singular ? dv_q[QB].lane[k].rsing
               : sat32(dv_q[QB].lane[k].neg,
                       dv_q[QB].lane[k].ovf ? {ADJ_W{1'b1}} : ADJ_W'(dv_q[QB].lane[k].quo));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      dvv_q       <= {dvv_q[QB-1:0], job_valid_i};
      out_valid_q <= dvv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= prep_d;
      for (int s = 0; s < QB; s++) begin
        dv_q[s+1] <= dv_nx[s];
      end
      res_q    <= res_d;
      status_q <= dv_q[QB].singular;
    end
  end

endmodule

// ----- hw/rtl/matrix3x3_inverse_unit.sv -----
// 3x3 fixed-point matrix inverse by adjugate. One matrix (nine signed Q16.16 words) per
// cycle is accepted and one result matrix per cycle is delivered without back-pressure;
// the path runs through 5 front stages forming adjugate, determinant and the singular
// test, the queue, a prep stage, 33 divider stages (one quotient bit each, nine
// lanes sharing the divisor) and the output register. A 4-entry queue separates front
// and divider so the input keeps flowing while a result waits. Status (tuser) is 1 when
// |det| < singular_threshold or det is zero; the adjugate is then returned shifted down
// by the fraction bits, otherwise adj/det. All results saturate to 32 bits.
module matrix3x3_inverse_unit import m3i_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // elem_r0c0..elem_r2c2, 32 bits each, lowest bits first
  input  logic [NUM_ELEM*ELEM_W-1:0]   s_axis_tdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // res_r0c0..res_r2c2, 32 bits each, lowest bits first
  output logic [NUM_ELEM*ELEM_W-1:0]   m_axis_tdata_o,
  // status
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [THR_W-1:0]     thr_q;
  elem_t [NUM_ELEM-1:0] in_elem, out_res;
  m3i_job_t             push_job, pop_job;
  logic                 push, pop, full, empty;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_THR_ADDR) ? {1'b0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_THR_ADDR) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign in_elem        = s_axis_tdata_i;
  assign m_axis_tdata_o = out_res;

  m3i_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_elem_i  (in_elem),
    .thr_i      (thr_q),
    .job_full_i (full),
    .job_push_o (push),
    .job_o      (push_job)
  );

  m3i_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_job)
  );

  m3i_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!empty),
    .job_i        (pop_job),
    .job_pop_o    (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_res_o    (out_res),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

// ----- test/testbench.sv -----
module testbench;
  import m3i_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NUM_ELEM*ELEM_W-1:0] matrix_t;

  typedef struct {
    matrix_t res;
    logic    singular;
  } inverse_t;

  typedef struct {
    matrix_t  mat;
    bit       typed;
    inverse_t want;
  } vector_t;

  logic                 clk_i;
  logic                 rst_ni;
  matrix_t              s_axis_tdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  matrix_t              m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  inverse_t   inverse_q[$];
  logic [THR_W-1:0] thr_model;
  int         errors;
  int         accepted;
  bit         long_hold;
  bit         no_gaps;

  matrix3x3_inverse_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    // elem_r0c0..elem_r2c2, lowest bits first
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    // res_r0c0..res_r2c2, lowest bits first
    .m_axis_tdata_o  (m_axis_tdata),
    // status
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic adj_t cofactor(input elem_t a, input elem_t b, input elem_t c,
                                    input elem_t d);
    adj_t pa, pb, pc, pd;
    pa = a; pb = b; pc = c; pd = d;
    return pa * pb - pc * pd;
  endfunction

  // adj/det, or adj shifted down by FRAC_BITS when |det| is under the threshold or zero
  function automatic inverse_t invert(input matrix_t m, input logic [THR_W-1:0] thr);
    elem_t                e[NUM_ELEM];
    adj_t                 a[NUM_ELEM];
    logic signed [127:0]  det, t0, t1, t2, x0, x1, x2;
    logic [127:0]         dmag, lim, mag;
    logic [63:0]          amag;
    logic                 dneg, neg;
    inverse_t             r;
    for (int i = 0; i < NUM_ELEM; i++) e[i] = m[ELEM_W*i +: ELEM_W];
    a[0] = cofactor(e[4], e[8], e[5], e[7]);
    a[1] = cofactor(e[2], e[7], e[1], e[8]);
    a[2] = cofactor(e[1], e[5], e[2], e[4]);
    a[3] = cofactor(e[5], e[6], e[3], e[8]);
    a[4] = cofactor(e[0], e[8], e[2], e[6]);
    a[5] = cofactor(e[2], e[3], e[0], e[5]);
    a[6] = cofactor(e[3], e[7], e[4], e[6]);
    a[7] = cofactor(e[1], e[6], e[0], e[7]);
    a[8] = cofactor(e[0], e[4], e[1], e[3]);
    t0 = e[0]; t1 = e[1]; t2 = e[2];
    x0 = a[0]; x1 = a[3]; x2 = a[6];
    det  = t0 * x0 + t1 * x1 + t2 * x2;
    dneg = det[127];
    dmag = dneg ? -det : det;
    lim  = {97'd0, thr} << (2 * FRAC_BITS);
    r.singular = (dmag < lim) || (dmag == 0);
    for (int i = 0; i < NUM_ELEM; i++) begin
      amag = a[i][63] ? -a[i] : a[i];
      if (r.singular) begin
        mag = {64'd0, amag >> FRAC_BITS};
        neg = a[i][63];
      end else begin
        mag = ({64'd0, amag} << (2 * FRAC_BITS)) / dmag;
        neg = a[i][63] ^ dneg;
      end
      if (!neg) r.res[ELEM_W*i +: ELEM_W] = (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      else      r.res[ELEM_W*i +: ELEM_W] = (mag > 128'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
    end
    return r;
  endfunction

  function automatic matrix_t mat(input int e0, e1, e2, e3, e4, e5, e6, e7, e8);
    return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
  endfunction

  function automatic int small_elem();
    return int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
  endfunction

  function automatic matrix_t random_matrix();
    int      e[NUM_ELEM];
    matrix_t m;
    int      sh;
    case ($urandom_range(0, 3))
      0: for (int i = 0; i < NUM_ELEM; i++) e[i] = $urandom;
      1: for (int i = 0; i < NUM_ELEM; i++) e[i] = small_elem();
      2: begin
        // third row nearly a sum of the others
        for (int i = 0; i < 6; i++) e[i] = small_elem();
        for (int i = 0; i < 3; i++) e[6+i] = e[i] + e[3+i] + int'($urandom_range(0, 6)) - 3;
      end
      default: begin
        sh = $urandom_range(0, 14);
        for (int i = 0; i < NUM_ELEM; i++) e[i] = small_elem() >>> sh;
        for (int i = 0; i < 3; i++) e[4*i] = e[4*i] + (int'($urandom_range(1, 255)) << 16);
      end
    endcase
    for (int i = 0; i < NUM_ELEM; i++) m[ELEM_W*i +: ELEM_W] = e[i];
    return m;
  endfunction

  task automatic report(input string what, input int idx, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch word %0d %s[%0d]: got %h want %h", accepted, what, idx, got, want);
    errors++;
  endtask

  task automatic send_matrix(input matrix_t m, input bit typed, input inverse_t want);
    int gap;
    s_axis_tdata  <= m;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    inverse_q.push_back(typed ? want : invert(m, thr_model));
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (!wr && prdata[THR_W-1:0] !== thr_model) report("threshold", addr, prdata, thr_model);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    wait (inverse_q.size() == 0);
    @(posedge clk_i);
    apb_access(1'b1, addr, value);
    if (addr == REG_THR_ADDR) thr_model = value[THR_W-1:0];
    @(posedge clk_i);
    apb_access(1'b0, REG_THR_ADDR, 32'd0);
  endtask

  task automatic random_phase(input int count);
    inverse_t none;
    for (int i = 0; i < count; i++) begin
      no_gaps = ((i / 40) % 3) == 1;
      send_matrix(random_matrix(), 1'b0, none);
    end
  endtask

  // output side: random stalls, and one long hold-off on request
  initial begin
    int stall;
    inverse_t w;
    m_axis_tready = 1'b0;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_q.size() == 0) begin
          report("unexpected", 0, m_axis_tuser, 0);
        end else begin
          w = inverse_q.pop_front();
          for (int i = 0; i < NUM_ELEM; i++)
            if (m_axis_tdata[ELEM_W*i +: ELEM_W] !== w.res[ELEM_W*i +: ELEM_W])
              report("res", i, m_axis_tdata[ELEM_W*i +: ELEM_W], w.res[ELEM_W*i +: ELEM_W]);
          if (m_axis_tuser !== w.singular) report("status", 0, m_axis_tuser, w.singular);
        end
        accepted++;
        stall = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (long_hold) begin
        long_hold = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    vector_t  tbl[$];
    vector_t  v;
    inverse_t none;
    matrix_t  zero;
    zero = '0;
    errors = 0; accepted = 0; long_hold = 1'b0; no_gaps = 1'b0;
    thr_model = THR_RESET;
    rst_ni = 1'b0;
    s_axis_tdata = '0; s_axis_tvalid = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, REG_THR_ADDR, 32'd0);

    // identity, zero, rank-deficient extremes, largest diagonal, sub-threshold, negatives
    tbl.push_back('{mat(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000), 1,
                    '{mat(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000), 1'b0}});
    tbl.push_back('{zero, 1, '{zero, 1'b1}});
    tbl.push_back('{{NUM_ELEM{32'h7FFF_FFFF}}, 1, '{zero, 1'b1}});
    tbl.push_back('{{NUM_ELEM{32'h8000_0000}}, 1, '{zero, 1'b1}});
    tbl.push_back('{mat(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000), 1,
                    '{mat(-2, 0, 0, 0, -2, 0, 0, 0, -2), 1'b0}});
    tbl.push_back('{mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1, '{zero, 1'b1}});
    tbl.push_back('{mat(-32'h10000, 0, 0, 0, -32'h10000, 0, 0, 0, -32'h10000), 1,
                    '{mat(-32'h10000, 0, 0, 0, -32'h10000, 0, 0, 0, -32'h10000), 1'b0}});
    tbl.push_back('{mat(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0), 0, none});
    tbl.push_back('{mat(32'h20000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h20000), 0, none});
    tbl.push_back('{mat(0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0), 0, none});
    tbl.push_back('{mat(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'hAAAA_AAAA), 0, none});
    tbl.push_back('{mat(32'h30000, -32'h8000, 32'h1234, 32'h4000, 32'h28000, -32'h777,
                        -32'h10000, 32'h2000, 32'h18000), 0, none});
    tbl.push_back('{mat(32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
                        32'h70000, 32'h80000, 32'h90001), 0, none});
    tbl.push_back('{mat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                        -1, 32'h7FFF_FFFF, 0, 32'h8000_0000), 0, none});
    foreach (tbl[i]) send_matrix(tbl[i].mat, tbl[i].typed, tbl[i].want);
    random_phase(180);

    // zero threshold: exactly singular still flagged, tiny det saturates
    set_threshold(REG_THR_ADDR, 32'd0);
    send_matrix(zero, 1'b1, '{zero, 1'b1});
    send_matrix(mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0, none);
    long_hold = 1'b1;
    random_phase(160);

    set_threshold(REG_THR_ADDR, 32'h7FFF_FFFF);
    random_phase(100);
    // unmapped register address is ignored
    set_threshold(3'd4, 32'h0000_0123);

    set_threshold(REG_THR_ADDR, $urandom_range(0, 32'h0010_0000));
    random_phase(150);
    set_threshold(REG_THR_ADDR, $urandom & 32'h7FFF_FFFF | 32'h8000_0000);
    random_phase(140);

    s_axis_tvalid <= 1'b0;
    wait (inverse_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_front.sv
hw/rtl/m3i_fifo.sv
hw/rtl/m3i_back.sv
hw/rtl/matrix3x3_inverse_unit.sv
test/testbench.sv
